// ===== hw/rtl/rmbv_pkg.sv =====
// ----------------------------------------------------------------------------
// rmbv_pkg
// Shared constants, types and rounding helpers for the rotation matrix unit.
// ----------------------------------------------------------------------------
package rmbv_pkg;

   // fixed-point format of vectors and matrix entries (signed Q1.14)
   localparam int FRAC_BITS  = 14;
   localparam int NORM_GUARD = 15;
   localparam int VEC_W      = 16;

   // wide working width for rounding and clamping
   localparam int WORK_W = 48;
   localparam logic signed [WORK_W-1:0] ONE_W  = WORK_W'(1) << FRAC_BITS;
   localparam logic        [WORK_W-1:0] HALF_W = WORK_W'(1) << (FRAC_BITS - 1);

   // register reset values
   localparam logic [VEC_W-1:0] TARGET_X_RESET = 16'h0000;
   localparam logic [VEC_W-1:0] TARGET_Y_RESET = 16'h0000;
   localparam logic [VEC_W-1:0] TARGET_Z_RESET = 16'h4000;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_TARGET_X = 2'd0,
      CSR_TARGET_Y = 2'd1,
      CSR_TARGET_Z = 2'd2
   } csr_index_type;

   // zero-vector flags that travel with an item
   typedef struct packed {
      logic src_zero;
      logic tgt_zero;
   } zflag_type;

   // divide by ONE, rounding half away from zero
   function automatic logic signed [WORK_W-1:0] round_frac(
      input logic signed [WORK_W-1:0] val);
      logic [WORK_W-1:0] mag;
      logic [WORK_W-1:0] quo;
      mag = val[WORK_W-1] ? WORK_W'(-val) : WORK_W'(val);
      quo = (mag + HALF_W) >> FRAC_BITS;
      round_frac = val[WORK_W-1] ? -$signed(quo) : $signed(quo);
   endfunction

   // clamp to [-ONE, ONE]
   function automatic logic signed [WORK_W-1:0] clamp_one(
      input logic signed [WORK_W-1:0] val);
      if (val > ONE_W) begin
         clamp_one = ONE_W;
      end else if (val < -ONE_W) begin
         clamp_one = -ONE_W;
      end else begin
         clamp_one = val;
      end
   endfunction

   // magnitude of a 16-bit signed value
   function automatic logic [VEC_W-1:0] mag16(input logic signed [VEC_W-1:0] val);
      mag16 = val[VEC_W-1] ? VEC_W'(-val) : VEC_W'(val);
   endfunction

endpackage

// ===== hw/rtl/rmbv_isqrt.sv =====
// ----------------------------------------------------------------------------
// rmbv_isqrt
// Pipelined integer square root, one result bit per stage, with side payload.
// ----------------------------------------------------------------------------
module rmbv_isqrt #(
   parameter int IN_W  = 32,
   parameter int PAY_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [IN_W-1:0]      in_radicand,
   input  logic [PAY_W-1:0]     in_payload,
   output logic                 out_valid,
   output logic [IN_W/2-1:0]    out_root,
   output logic [PAY_W-1:0]     out_payload
);

   localparam int OUT_W = IN_W / 2;
   localparam int RW    = OUT_W + 2;

   logic              valid_ff [OUT_W];
   logic [RW-1:0]     rem_ff   [OUT_W];
   logic [OUT_W-1:0]  root_ff  [OUT_W];
   logic [IN_W-1:0]   rad_ff   [OUT_W];
   logic [PAY_W-1:0]  pay_ff   [OUT_W];

   for (genvar j = 0; j < OUT_W; j++) begin : g_stage
      logic              val_prev;
      logic [RW-1:0]     rem_prev;
      logic [OUT_W-1:0]  root_prev;
      logic [IN_W-1:0]   rad_prev;
      logic [PAY_W-1:0]  pay_prev;
      logic [RW-1:0]     rem_sh;
      logic [RW-1:0]     trial;
      logic [RW-1:0]     rem_in;
      logic [OUT_W-1:0]  root_in;

      if (j == 0) begin : g_first
         assign val_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_radicand;
         assign pay_prev  = in_payload;
      end else begin : g_next
         assign val_prev  = valid_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign rad_prev  = rad_ff[j-1];
         assign pay_prev  = pay_ff[j-1];
      end

      // bring down the next bit pair and try the next root bit
      assign rem_sh = {rem_prev[RW-3:0], rad_prev[2*(OUT_W-1-j)+1 -: 2]};
      assign trial  = {root_prev, 2'b01};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[OUT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[OUT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv) begin
            valid_ff[j] <= val_prev;
         end
         if (adv) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            rad_ff[j]  <= rad_prev;
            pay_ff[j]  <= pay_prev;
         end
      end
   end

   assign out_valid   = valid_ff[OUT_W-1];
   assign out_root    = root_ff[OUT_W-1];
   assign out_payload = pay_ff[OUT_W-1];

endmodule

// ===== hw/rtl/rmbv_div.sv =====
// ----------------------------------------------------------------------------
// rmbv_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor,
// several lanes, with side payload.
// ----------------------------------------------------------------------------
module rmbv_div #(
   parameter int NUM_W = 47,
   parameter int DEN_W = 31,
   parameter int LANES = 3,
   parameter int PAY_W = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]          in_num,
   input  logic [DEN_W-1:0]                     in_den,
   input  logic [PAY_W-1:0]                     in_payload,
   output logic                                 out_valid,
   output logic [LANES-1:0][NUM_W-DEN_W-1:0]    out_quot,
   output logic [PAY_W-1:0]                     out_payload
);

   localparam int Q_W = NUM_W - DEN_W;

   logic                          valid_ff [Q_W];
   logic [LANES-1:0][NUM_W-1:0]   rem_ff   [Q_W];
   logic [LANES-1:0][Q_W-1:0]     quot_ff  [Q_W];
   logic [DEN_W-1:0]              den_ff   [Q_W];
   logic [PAY_W-1:0]              pay_ff   [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      logic                          val_prev;
      logic [LANES-1:0][NUM_W-1:0]   rem_prev;
      logic [LANES-1:0][Q_W-1:0]     quot_prev;
      logic [DEN_W-1:0]              den_prev;
      logic [PAY_W-1:0]              pay_prev;
      logic [NUM_W-1:0]              cand;
      logic [LANES-1:0][NUM_W-1:0]   rem_in;
      logic [LANES-1:0][Q_W-1:0]     quot_in;

      if (j == 0) begin : g_first
         assign val_prev  = in_valid;
         assign rem_prev  = in_num;
         assign quot_prev = '0;
         assign den_prev  = in_den;
         assign pay_prev  = in_payload;
      end else begin : g_next
         assign val_prev  = valid_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign quot_prev = quot_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign pay_prev  = pay_ff[j-1];
      end

      // divisor aligned to this quotient bit
      assign cand = NUM_W'(den_prev) << (Q_W - 1 - j);

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (rem_prev[l] >= cand) begin
               rem_in[l]  = rem_prev[l] - cand;
               quot_in[l] = {quot_prev[l][Q_W-2:0], 1'b1};
            end else begin
               rem_in[l]  = rem_prev[l];
               quot_in[l] = {quot_prev[l][Q_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv) begin
            valid_ff[j] <= val_prev;
         end
         if (adv) begin
            rem_ff[j]  <= rem_in;
            quot_ff[j] <= quot_in;
            den_ff[j]  <= den_prev;
            pay_ff[j]  <= pay_prev;
         end
      end
   end

   assign out_valid   = valid_ff[Q_W-1];
   assign out_quot    = quot_ff[Q_W-1];
   assign out_payload = pay_ff[Q_W-1];

endmodule

// ===== hw/rtl/rotation_matrix_between_vectors_unit.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_between_vectors_unit
// Rodrigues rotation taking a source vector onto the configured target vector,
// signed Q1.14, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata: source x,y,z
//  rsp     | out       | rsp_tvalid/tready    | tdata: r00..r22, tuser: degenerate
//  csr     | in        | csr_valid/ready      | csr_index, csr_data (target x,y,z)
//
//  One transaction per cycle while the output is not stalled; the path runs through the two square
//  root and two divider pipelines (one bit per stage) plus 14 arithmetic stages.
//  Reset clears all valid bits and loads the default target (0, 0, 1.0).
//  The whole pipeline holds while the output register is full and not taken;
//  nothing is dropped or repeated. csr writes are always taken.
// ----------------------------------------------------------------------------
module rotation_matrix_between_vectors_unit
   import rmbv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   // request stream
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [47:0]    req_tdata,   // source_x, source_y, source_z
   // response stream
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [143:0]   rsp_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
   output logic [0:0]     rsp_tuser,   // degenerate
   // configuration writes
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [1:0]     csr_index,
   input  logic [15:0]    csr_data
);

   localparam int SQ_W   = 32;
   localparam int LEN_W  = 31;
   localparam int NUMA_W = 47;
   localparam int QA_W   = NUMA_W - LEN_W;
   localparam int S_W    = 16;
   localparam int NUMK_W = 32;
   localparam int QK_W   = NUMK_W - S_W;
   localparam int W_W    = 17;
   localparam int K_W    = 17;
   localparam int T_W    = 17;
   localparam int KR_W   = 20;
   localparam int OR_W   = 22;

   logic adv;

   // ------------------------------------------------------------------------
   // configuration registers
   logic [VEC_W-1:0] target_x_ff, target_y_ff, target_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff <= TARGET_X_RESET;
         target_y_ff <= TARGET_Y_RESET;
         target_z_ff <= TARGET_Z_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET_X: target_x_ff <= csr_data;
            CSR_TARGET_Y: target_y_ff <= csr_data;
            CSR_TARGET_Z: target_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline moves when the output register is empty or being drained
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ------------------------------------------------------------------------
   // stage 1: squares of source and target components
   logic signed [VEC_W-1:0] a_in [3];
   logic signed [VEC_W-1:0] b_in [3];

   assign a_in[0] = req_tdata[15:0];
   assign a_in[1] = req_tdata[31:16];
   assign a_in[2] = req_tdata[47:32];
   assign b_in[0] = target_x_ff;
   assign b_in[1] = target_y_ff;
   assign b_in[2] = target_z_ff;

   logic                    s1_valid_ff;
   logic signed [VEC_W-1:0] s1_a_ff [3];
   logic signed [VEC_W-1:0] s1_b_ff [3];
   logic [SQ_W-1:0]         s1_asq_ff [3];
   logic [SQ_W-1:0]         s1_bsq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s1_a_ff[i]   <= a_in[i];
            s1_b_ff[i]   <= b_in[i];
            s1_asq_ff[i] <= SQ_W'(a_in[i] * a_in[i]);
            s1_bsq_ff[i] <= SQ_W'(b_in[i] * b_in[i]);
         end
      end
   end

   // stage 2: squared lengths and zero flags
   logic                    s2_valid_ff;
   logic signed [VEC_W-1:0] s2_a_ff [3];
   logic signed [VEC_W-1:0] s2_b_ff [3];
   logic [SQ_W-1:0]         s2_asum_ff, s2_bsum_ff;
   zflag_type               s2_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s2_a_ff           <= s1_a_ff;
         s2_b_ff           <= s1_b_ff;
         s2_asum_ff        <= s1_asq_ff[0] + s1_asq_ff[1] + s1_asq_ff[2];
         s2_bsum_ff        <= s1_bsq_ff[0] + s1_bsq_ff[1] + s1_bsq_ff[2];
         s2_zf_ff.src_zero <= (s1_a_ff[0] == '0) && (s1_a_ff[1] == '0) && (s1_a_ff[2] == '0);
         s2_zf_ff.tgt_zero <= (s1_b_ff[0] == '0) && (s1_b_ff[1] == '0) && (s1_b_ff[2] == '0);
      end
   end

   // ------------------------------------------------------------------------
   // vector lengths with guard bits
   localparam int PA_W = 2 + 3 * VEC_W;
   localparam int PB_W = 3 * VEC_W;

   logic             la_valid, lb_valid_unused;
   logic [LEN_W-1:0] la_len, lb_len;
   logic [PA_W-1:0]  la_pay;
   logic [PB_W-1:0]  lb_pay;

   rmbv_isqrt #(.IN_W(2 * LEN_W), .PAY_W(PA_W)) u_len_src (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (s2_valid_ff),
      .in_radicand ({s2_asum_ff, (2 * NORM_GUARD)'(0)}),
      .in_payload  ({s2_zf_ff, s2_a_ff[2], s2_a_ff[1], s2_a_ff[0]}),
      .out_valid   (la_valid),
      .out_root    (la_len),
      .out_payload (la_pay)
   );

   rmbv_isqrt #(.IN_W(2 * LEN_W), .PAY_W(PB_W)) u_len_tgt (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (s2_valid_ff),
      .in_radicand ({s2_bsum_ff, (2 * NORM_GUARD)'(0)}),
      .in_payload  ({s2_b_ff[2], s2_b_ff[1], s2_b_ff[0]}),
      .out_valid   (lb_valid_unused),
      .out_root    (lb_len),
      .out_payload (lb_pay)
   );

   // normalize: |x| * 2^(FRAC+GUARD) + L/2, divided by L
   logic [2:0][NUMA_W-1:0] na_num, nb_num;
   logic [2:0]             a_sign, b_sign;
   zflag_type              la_zf;

   assign la_zf = la_pay[PA_W-1 -: 2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_sign[i] = la_pay[VEC_W*i + VEC_W-1];
         b_sign[i] = lb_pay[VEC_W*i + VEC_W-1];
         na_num[i] = {mag16(la_pay[VEC_W*i +: VEC_W]), (FRAC_BITS + NORM_GUARD)'(0)}
                     + NUMA_W'(la_len >> 1);
         nb_num[i] = {mag16(lb_pay[VEC_W*i +: VEC_W]), (FRAC_BITS + NORM_GUARD)'(0)}
                     + NUMA_W'(lb_len >> 1);
      end
   end

   logic                 qa_valid, qb_valid_unused;
   logic [2:0][QA_W-1:0] qa_quot, qb_quot;
   logic [4:0]           qa_pay;
   logic [2:0]           qb_pay;

   rmbv_div #(.NUM_W(NUMA_W), .DEN_W(LEN_W), .LANES(3), .PAY_W(5)) u_div_src (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (la_valid),
      .in_num      (na_num),
      .in_den      (la_len),
      .in_payload  ({la_zf, a_sign}),
      .out_valid   (qa_valid),
      .out_quot    (qa_quot),
      .out_payload (qa_pay)
   );

   rmbv_div #(.NUM_W(NUMA_W), .DEN_W(LEN_W), .LANES(3), .PAY_W(3)) u_div_tgt (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (la_valid),
      .in_num      (nb_num),
      .in_den      (lb_len),
      .in_payload  (b_sign),
      .out_valid   (qb_valid_unused),
      .out_quot    (qb_quot),
      .out_payload (qb_pay)
   );

   // unit vectors: apply sign and clamp
   logic signed [VEC_W-1:0] u_in [3];
   logic signed [VEC_W-1:0] v_in [3];

   always_comb begin
      logic signed [WORK_W-1:0] ta;
      logic signed [WORK_W-1:0] tb;
      for (int i = 0; i < 3; i++) begin
         ta = WORK_W'($signed({1'b0, qa_quot[i]}));
         tb = WORK_W'($signed({1'b0, qb_quot[i]}));
         if (qa_pay[i]) begin
            ta = -ta;
         end
         if (qb_pay[i]) begin
            tb = -tb;
         end
         u_in[i] = VEC_W'(clamp_one(ta));
         v_in[i] = VEC_W'(clamp_one(tb));
      end
   end

   logic                    un_valid_ff;
   logic signed [VEC_W-1:0] un_u_ff [3];
   logic signed [VEC_W-1:0] un_v_ff [3];
   zflag_type               un_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         un_valid_ff <= 1'b0;
      end else if (adv) begin
         un_valid_ff <= qa_valid;
      end
      if (adv) begin
         un_u_ff  <= u_in;
         un_v_ff  <= v_in;
         un_zf_ff <= qa_pay[4:3];
      end
   end

   // ------------------------------------------------------------------------
   // x1: all pairwise products u_i * v_j
   logic                     x1_valid_ff;
   logic signed [2*VEC_W-1:0] x1_p_ff [3][3];
   zflag_type                x1_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_valid_ff <= 1'b0;
      end else if (adv) begin
         x1_valid_ff <= un_valid_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               x1_p_ff[i][j] <= un_u_ff[i] * un_v_ff[j];
            end
         end
         x1_zf_ff <= un_zf_ff;
      end
   end

   // x2: dot product and cross product sums
   logic                    x2_valid_ff;
   logic signed [33:0]      x2_dot_ff;
   logic signed [32:0]      x2_cr_ff [3];
   zflag_type               x2_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x2_valid_ff <= 1'b0;
      end else if (adv) begin
         x2_valid_ff <= x1_valid_ff;
      end
      if (adv) begin
         x2_dot_ff   <= 34'(x1_p_ff[0][0]) + 34'(x1_p_ff[1][1]) + 34'(x1_p_ff[2][2]);
         x2_cr_ff[0] <= 33'(x1_p_ff[1][2]) - 33'(x1_p_ff[2][1]);
         x2_cr_ff[1] <= 33'(x1_p_ff[2][0]) - 33'(x1_p_ff[0][2]);
         x2_cr_ff[2] <= 33'(x1_p_ff[0][1]) - 33'(x1_p_ff[1][0]);
         x2_zf_ff    <= x1_zf_ff;
      end
   end

   // x3: rescale cosine and cross product
   logic                    x3_valid_ff;
   logic signed [VEC_W-1:0] x3_c_ff;
   logic signed [W_W-1:0]   x3_w_ff [3];
   zflag_type               x3_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x3_valid_ff <= 1'b0;
      end else if (adv) begin
         x3_valid_ff <= x2_valid_ff;
      end
      if (adv) begin
         x3_c_ff <= VEC_W'(clamp_one(round_frac(WORK_W'(x2_dot_ff))));
         for (int i = 0; i < 3; i++) begin
            x3_w_ff[i] <= W_W'(round_frac(WORK_W'(x2_cr_ff[i])));
         end
         x3_zf_ff <= x2_zf_ff;
      end
   end

   // x4: squares of the cross product
   logic                    x4_valid_ff;
   logic signed [VEC_W-1:0] x4_c_ff;
   logic signed [W_W-1:0]   x4_w_ff [3];
   logic [SQ_W-1:0]         x4_wsq_ff [3];
   logic                    x4_wz_ff;
   zflag_type               x4_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x4_valid_ff <= 1'b0;
      end else if (adv) begin
         x4_valid_ff <= x3_valid_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            x4_wsq_ff[i] <= SQ_W'(x3_w_ff[i] * x3_w_ff[i]);
         end
         x4_wz_ff <= (x3_w_ff[0] == '0) && (x3_w_ff[1] == '0) && (x3_w_ff[2] == '0);
         x4_c_ff  <= x3_c_ff;
         x4_w_ff  <= x3_w_ff;
         x4_zf_ff <= x3_zf_ff;
      end
   end

   // x5: squared sine
   logic                    x5_valid_ff;
   logic signed [VEC_W-1:0] x5_c_ff;
   logic signed [W_W-1:0]   x5_w_ff [3];
   logic [SQ_W-1:0]         x5_wsum_ff;
   logic                    x5_wz_ff;
   zflag_type               x5_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x5_valid_ff <= 1'b0;
      end else if (adv) begin
         x5_valid_ff <= x4_valid_ff;
      end
      if (adv) begin
         x5_wsum_ff <= x4_wsq_ff[0] + x4_wsq_ff[1] + x4_wsq_ff[2];
         x5_c_ff    <= x4_c_ff;
         x5_w_ff    <= x4_w_ff;
         x5_wz_ff   <= x4_wz_ff;
         x5_zf_ff   <= x4_zf_ff;
      end
   end

   // ------------------------------------------------------------------------
   // sine = sqrt(w.w)
   localparam int PS_W = 2 + 1 + VEC_W + 3 * W_W;

   logic            sn_valid;
   logic [S_W-1:0]  sn_s;
   logic [PS_W-1:0] sn_pay;

   rmbv_isqrt #(.IN_W(SQ_W), .PAY_W(PS_W)) u_sine (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (x5_valid_ff),
      .in_radicand (x5_wsum_ff),
      .in_payload  ({x5_zf_ff, x5_wz_ff, x5_c_ff, x5_w_ff[2], x5_w_ff[1], x5_w_ff[0]}),
      .out_valid   (sn_valid),
      .out_root    (sn_s),
      .out_payload (sn_pay)
   );

   // axis k = w * ONE / s, rounded
   localparam int PK_W = 2 + 1 + VEC_W + S_W + 3;

   logic [2:0][NUMK_W-1:0] nk_num;
   logic [2:0]             w_sign;

   always_comb begin
      logic signed [W_W-1:0] wv;
      logic [W_W-1:0]        wm;
      for (int i = 0; i < 3; i++) begin
         wv        = sn_pay[W_W*i +: W_W];
         wm        = wv[W_W-1] ? W_W'(-wv) : W_W'(wv);
         w_sign[i] = wv[W_W-1];
         nk_num[i] = {wm[VEC_W-1:0], FRAC_BITS'(0)} + NUMK_W'(sn_s >> 1);
      end
   end

   logic                 kq_valid;
   logic [2:0][QK_W-1:0] kq_quot;
   logic [PK_W-1:0]      kq_pay;

   rmbv_div #(.NUM_W(NUMK_W), .DEN_W(S_W), .LANES(3), .PAY_W(PK_W)) u_axis (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (sn_valid),
      .in_num      (nk_num),
      .in_den      (sn_s),
      .in_payload  ({sn_pay[PS_W-1 -: 3 + VEC_W], sn_s, w_sign}),
      .out_valid   (kq_valid),
      .out_quot    (kq_quot),
      .out_payload (kq_pay)
   );

   // k stage: signed axis, clamped sine, 1 - cosine
   logic signed [VEC_W-1:0] kq_c;
   logic [S_W-1:0]          kq_s;

   assign kq_c = kq_pay[3 + S_W +: VEC_W];
   assign kq_s = kq_pay[3 +: S_W];

   logic                    k_valid_ff;
   logic signed [K_W-1:0]   k_k_ff [3];
   logic [S_W-1:0]          k_s_ff;
   logic signed [VEC_W-1:0] k_c_ff;
   logic signed [T_W-1:0]   k_t_ff;
   logic                    k_wz_ff;
   zflag_type               k_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_valid_ff <= 1'b0;
      end else if (adv) begin
         k_valid_ff <= kq_valid;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            k_k_ff[i] <= kq_pay[i] ? -$signed({1'b0, kq_quot[i]}) : $signed({1'b0, kq_quot[i]});
         end
         k_s_ff  <= (kq_s > S_W'(ONE_W)) ? S_W'(ONE_W) : kq_s;
         k_c_ff  <= kq_c;
         k_t_ff  <= T_W'(ONE_W) - T_W'(kq_c);
         k_wz_ff <= kq_pay[PK_W-3];
         k_zf_ff <= kq_pay[PK_W-1 -: 2];
      end
   end

   // ------------------------------------------------------------------------
   // p1: k_i*k_j and k_i*s
   logic                        p1_valid_ff;
   logic signed [2*K_W-1:0]     p1_kk_ff [3][3];
   logic signed [2*K_W-1:0]     p1_sk_ff [3];
   logic signed [VEC_W-1:0]     p1_c_ff;
   logic signed [T_W-1:0]       p1_t_ff;
   logic                        p1_wz_ff;
   zflag_type                   p1_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= k_valid_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p1_kk_ff[i][j] <= k_k_ff[i] * k_k_ff[j];
            end
            p1_sk_ff[i] <= k_k_ff[i] * $signed({1'b0, k_s_ff});
         end
         p1_c_ff  <= k_c_ff;
         p1_t_ff  <= k_t_ff;
         p1_wz_ff <= k_wz_ff;
         p1_zf_ff <= k_zf_ff;
      end
   end

   // p2: rescale products
   logic                    p2_valid_ff;
   logic signed [KR_W-1:0]  p2_kk_ff [3][3];
   logic signed [KR_W-1:0]  p2_sk_ff [3];
   logic signed [VEC_W-1:0] p2_c_ff;
   logic signed [T_W-1:0]   p2_t_ff;
   logic                    p2_wz_ff;
   zflag_type               p2_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p2_kk_ff[i][j] <= KR_W'(round_frac(WORK_W'(p1_kk_ff[i][j])));
            end
            p2_sk_ff[i] <= KR_W'(round_frac(WORK_W'(p1_sk_ff[i])));
         end
         p2_c_ff  <= p1_c_ff;
         p2_t_ff  <= p1_t_ff;
         p2_wz_ff <= p1_wz_ff;
         p2_zf_ff <= p1_zf_ff;
      end
   end

   // p3: outer terms times (1 - c)
   logic                         p3_valid_ff;
   logic signed [KR_W+T_W-1:0]   p3_o_ff [3][3];
   logic signed [KR_W-1:0]       p3_sk_ff [3];
   logic signed [VEC_W-1:0]      p3_c_ff;
   logic                         p3_wz_ff;
   zflag_type                    p3_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p3_o_ff[i][j] <= p2_kk_ff[i][j] * p2_t_ff;
            end
         end
         p3_sk_ff <= p2_sk_ff;
         p3_c_ff  <= p2_c_ff;
         p3_wz_ff <= p2_wz_ff;
         p3_zf_ff <= p2_zf_ff;
      end
   end

   // p4: rescale outer terms
   logic                    p4_valid_ff;
   logic signed [OR_W-1:0]  p4_o_ff [3][3];
   logic signed [KR_W-1:0]  p4_sk_ff [3];
   logic signed [VEC_W-1:0] p4_c_ff;
   logic                    p4_wz_ff;
   zflag_type               p4_zf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (adv) begin
         p4_valid_ff <= p3_valid_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p4_o_ff[i][j] <= OR_W'(round_frac(WORK_W'(p3_o_ff[i][j])));
            end
         end
         p4_sk_ff <= p3_sk_ff;
         p4_c_ff  <= p3_c_ff;
         p4_wz_ff <= p3_wz_ff;
         p4_zf_ff <= p3_zf_ff;
      end
   end

   // ------------------------------------------------------------------------
   // output: assemble entries, clamp, special cases
   logic signed [WORK_W-1:0] skew [3][3];
   logic [143:0]             rsp_tdata_in;
   logic [143:0]             rsp_tdata_ff;
   logic [0:0]               rsp_tuser_ff;
   logic                     rsp_tvalid_ff;

   always_comb begin
      logic signed [WORK_W-1:0] sk0, sk1, sk2, cw, ent;
      sk0 = WORK_W'(p4_sk_ff[0]);
      sk1 = WORK_W'(p4_sk_ff[1]);
      sk2 = WORK_W'(p4_sk_ff[2]);
      cw  = WORK_W'(p4_c_ff);
      skew[0][0] = cw;
      skew[0][1] = -sk2;
      skew[0][2] = sk1;
      skew[1][0] = sk2;
      skew[1][1] = cw;
      skew[1][2] = -sk0;
      skew[2][0] = -sk1;
      skew[2][1] = sk0;
      skew[2][2] = cw;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (p4_zf_ff.src_zero || p4_zf_ff.tgt_zero) begin
               ent = '0;
            end else if (p4_wz_ff) begin
               ent = (i == j) ? cw : '0;
            end else begin
               ent = clamp_one(WORK_W'(p4_o_ff[i][j]) + skew[i][j]);
            end
            rsp_tdata_in[VEC_W*(3*i+j) +: VEC_W] = ent[VEC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= p4_valid_ff;
      end
      if (adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= p4_zf_ff.src_zero;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== hw/rtl/rmbv_checker.sv =====
// ----------------------------------------------------------------------------
// rmbv_checker
// Port-level checks for the rotation matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
module rmbv_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // no response right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // input stalls exactly when a waiting result is not taken
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");

   // degenerate source yields the zero matrix
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("degenerate result is not zero");

   // diagonal entry stays within [-1, 1]
   a_r00_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) >= -16'sd16384)
                  && ($signed(rsp_tdata[15:0]) <= 16'sd16384))
      else $error("r00 out of range");

endmodule

bind rotation_matrix_between_vectors_unit rmbv_checker u_rmbv_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the rotation matrix unit: each source vector is turned into an
// expected Rodrigues matrix by a local fixed-point predictor and compared
// field by field with the response stream, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb
   import rmbv_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 93;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct {
      logic [15:0] entry [9];
      logic        degenerate;
   } rotation_type;

   logic           clock;
   logic           reset;
   logic           req_tvalid;
   logic           req_tready;
   logic [47:0]    req_tdata;   // source_x, source_y, source_z
   logic           rsp_tvalid;
   logic           rsp_tready;
   logic [143:0]   rsp_tdata;   // r00, r01, r02, r10, r11, r12, r20, r21, r22
   logic [0:0]     rsp_tuser;   // degenerate
   logic           csr_valid;
   logic           csr_ready;
   logic [1:0]     csr_index;
   logic [15:0]    csr_data;

   // target vector as the predictor sees it
   logic [15:0]    target_vec [3];
   rotation_type   expected_rotations [$];
   int             fail_count;
   int             rotation_count;
   int             target_count;
   int             cycle_count;
   bit             idle_enable;

   rotation_matrix_between_vectors_unit i_dut (.*);

   // clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ---- predictor ----
   function automatic longint rnd_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clamp_unit(longint v);
      longint one;
      one = longint'(1) << FRAC_BITS;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = longint'(1) << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic void normalize(input longint x [3], output longint u [3]);
      longint unsigned sq;
      longint len;
      sq = 0;
      for (int i = 0; i < 3; i++) sq += longint'(x[i] * x[i]);
      len = int_sqrt(sq << (2 * NORM_GUARD));
      for (int i = 0; i < 3; i++)
         u[i] = clamp_unit(rnd_div(x[i] * (longint'(1) << (FRAC_BITS + NORM_GUARD)), len));
   endfunction

   function automatic rotation_type predict_rotation(logic [15:0] src [3]);
      rotation_type res;
      longint one, a [3], b [3], u [3], v [3], w [3], k [3], r [9];
      longint c, s, t, sk0, sk1, sk2;
      longint unsigned wsq;
      bit src_zero, tgt_zero;
      one = longint'(1) << FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'($signed(src[i]));
         b[i] = longint'($signed(target_vec[i]));
      end
      for (int i = 0; i < 9; i++) r[i] = 0;
      src_zero = (a[0] == 0 && a[1] == 0 && a[2] == 0);
      tgt_zero = (b[0] == 0 && b[1] == 0 && b[2] == 0);
      if (!src_zero && !tgt_zero) begin
         normalize(a, u);
         normalize(b, v);
         c = clamp_unit(rnd_div(u[0] * v[0] + u[1] * v[1] + u[2] * v[2], one));
         w[0] = rnd_div(u[1] * v[2] - u[2] * v[1], one);
         w[1] = rnd_div(u[2] * v[0] - u[0] * v[2], one);
         w[2] = rnd_div(u[0] * v[1] - u[1] * v[0], one);
         if (w[0] == 0 && w[1] == 0 && w[2] == 0) begin
            // parallel or antiparallel: scaled identity
            r[0] = c;
            r[4] = c;
            r[8] = c;
         end else begin
            wsq = 0;
            for (int i = 0; i < 3; i++) wsq += longint'(w[i] * w[i]);
            s = int_sqrt(wsq);
            for (int i = 0; i < 3; i++) k[i] = rnd_div(w[i] * one, s);
            if (s > one) s = one;
            t = one - c;
            sk0 = rnd_div(k[0] * s, one);
            sk1 = rnd_div(k[1] * s, one);
            sk2 = rnd_div(k[2] * s, one);
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++)
                  r[i*3+j] = rnd_div(rnd_div(k[i] * k[j], one) * t, one);
            r[0] += c;
            r[4] += c;
            r[8] += c;
            r[1] -= sk2;
            r[2] += sk1;
            r[3] += sk2;
            r[5] -= sk0;
            r[6] -= sk1;
            r[7] += sk0;
         end
      end
      for (int i = 0; i < 9; i++) res.entry[i] = 16'(clamp_unit(r[i]));
      res.degenerate = src_zero;
      return res;
   endfunction

   // ---- drivers ----
   // an idle burst drops valid; the next send raises it again
   task automatic idle_gap();
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      logic [15:0] src [3];
      src = '{x, y, z};
      idle_gap();
      req_tdata  <= {z, y, x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_rotations.insert(expected_rotations.size(), predict_rotation(src));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_rotations.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      target_vec[idx] = value;
      @(negedge clock);
   endtask

   task automatic set_target(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      wait_drained();
      write_csr(CSR_TARGET_X, x);
      write_csr(CSR_TARGET_Y, y);
      write_csr(CSR_TARGET_Z, z);
      csr_valid <= 1'b0;
      target_count++;
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0:       return 16'sd16384;
         1:       return -16'sd16384;
         2:       return 16'(int'($urandom_range(0, 6)) - 3);
         3:       return 16'($urandom);   // full 16-bit pattern, out of range too
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // ---- response check ----
   always @(posedge clock) begin
      rotation_type exp_rot;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rotations.size() == 0) begin
            $error("unexpected response transaction");
            fail_count++;
         end else begin
            exp_rot = expected_rotations.pop_front();
            rotation_count++;
            for (int i = 0; i < 9; i++)
               if (rsp_tdata[16*i +: 16] !== exp_rot.entry[i]) begin
                  $error("r%0d%0d expected %0d actual %0d", i / 3, i % 3,
                         $signed(exp_rot.entry[i]), $signed(rsp_tdata[16*i +: 16]));
                  fail_count++;
               end
            if (rsp_tuser[0] !== exp_rot.degenerate) begin
               $error("degenerate expected %0d actual %0d",
                      exp_rot.degenerate, rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---- tests ----
   task automatic test_special_cases();
      // default target, zero source, axes, extremes, parallel and antiparallel
      send_vector(16'sd0, 16'sd0, 16'sd0);
      send_vector(16'sd0, 16'sd0, 16'sd16384);
      send_vector(16'sd0, 16'sd0, -16'sd16384);
      send_vector(16'sd16384, 16'sd0, 16'sd0);
      send_vector(16'sd0, -16'sd16384, 16'sd0);
      send_vector(16'sd16384, 16'sd16384, 16'sd16384);
      send_vector(-16'sd16384, -16'sd16384, -16'sd16384);
      send_vector(16'h7fff, 16'h8000, 16'hffff);
      send_vector(16'sd1, 16'sd0, 16'sd0);
      send_vector(16'sd1, 16'sd1, 16'sd16384);
      send_vector(16'sd0, 16'sd0, 16'sd1);
      // zero target
      set_target(16'sd0, 16'sd0, 16'sd0);
      send_vector(16'sd100, 16'sd200, 16'sd300);
      send_vector(16'sd0, 16'sd0, 16'sd0);
      // extreme target
      set_target(-16'sd16384, 16'sd16384, -16'sd16384);
      send_vector(-16'sd16384, 16'sd16384, -16'sd16384);
      send_vector(16'sd16384, -16'sd16384, 16'sd16384);
      send_vector(16'sd3, 16'sd0, 16'sd0);
      // out-of-range target bits
      set_target(16'h8000, 16'h7fff, 16'hffff);
      send_vector(16'h7fff, 16'h8000, 16'h0001);
      send_vector(16'sd5, 16'sd7, 16'sd9);
   endtask

   task automatic test_random_vectors(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 300 == 0) set_target(rand_comp(), rand_comp(), rand_comp());
         if ($urandom_range(0, 9) == 0) begin
            // parallel to target: the target vector itself
            send_vector(target_vec[0], target_vec[1], target_vec[2]);
         end else begin
            send_vector(rand_comp(), rand_comp(), rand_comp());
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_TARGET_X;
      csr_data    = '0;
      fail_count  = 0;
      rotation_count = 0;
      target_count = 1;
      cycle_count = 0;
      idle_enable = 1'b1;
      target_vec  = '{TARGET_X_RESET, TARGET_Y_RESET, TARGET_Z_RESET};
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_special_cases();
      test_random_vectors(1500);
      // back-to-back stretch without idling
      wait_drained();
      idle_enable = 1'b0;
      set_target(16'sd0, 16'sd0, 16'sd16384);
      test_random_vectors(330);
      wait_drained();

      $display("Covered zero, parallel, extreme and random vectors over %0d targets;",
               target_count);
      $display("%0d rotation matrices compared.", rotation_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
